// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the timer table.
// Depends on nothing; included by the top level, which carries the assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mrstt_pkg.sv =====
// Types and constants of the timer table: opcodes, field widths and the
// command record that travels from the front end to the back end.
package mrstt_pkg;

  localparam int OPCODE_W = 2;
  localparam int RATE_W = 1;
  localparam int IDX_W = 4;
  localparam int FIELD_CNT_W = 16;
  localparam int RATE_SLOTS = 2;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK   = 2'd0,
    OP_ARM    = 2'd1,
    OP_DISARM = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [RATE_W-1:0]      rate;
    logic [IDX_W-1:0]       timer_index;
    logic                   idx_ok;
    logic                   rate_ok;
    logic [FIELD_CNT_W-1:0] start_count;
    logic [FIELD_CNT_W-1:0] reload_interval;
  } cmd_t;

endpackage

// ===== rtl/mrstt_if.sv =====
// Request and result channels of the timer table, each with valid and ready.
// Depends on mrstt_pkg for the field widths.
interface mrstt_req_if;
  import mrstt_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [OPCODE_W-1:0]    opcode;
  logic [RATE_W-1:0]      rate;
  logic [IDX_W-1:0]       timer_index;
  logic [FIELD_CNT_W-1:0] start_count;
  logic [FIELD_CNT_W-1:0] reload_interval;

  modport source(output valid, opcode, rate, timer_index, start_count, reload_interval,
                 input ready);
  modport sink(input valid, opcode, rate, timer_index, start_count, reload_interval,
               output ready);
endinterface

interface mrstt_res_if;
  import mrstt_pkg::*;
  logic             valid;
  logic             ready;
  logic             expired_valid;
  logic [IDX_W-1:0] expired_timer;
  logic             rate_idle;
  logic             was_armed;
  logic             last_item;

  modport source(output valid, expired_valid, expired_timer, rate_idle, was_armed, last_item,
                 input ready);
  modport sink(input valid, expired_valid, expired_timer, rate_idle, was_armed, last_item,
               output ready);
endinterface

// ===== rtl/multi_rate_software_timer_table.sv =====
// Top level of the multi-rate timer table: front end, command queue, back end.
// Depends on mrstt_pkg, mrstt_if, mrstt_front, mrstt_cmd_queue, mrstt_back, assert_macros.svh.
//
//   Channel  Dir  Handshake     Carries
//   req      in   valid/ready   opcode, rate, timer_index, start_count, reload_interval
//   res      out  valid/ready   expired_valid, expired_timer, rate_idle, was_armed, last_item
//
// Arm, disarm and query give one result each, via queue entry and result register.
// A tick of a valid rate sweeps the table through one read port of the timer memories,
// one entry a cycle while no expiry waits on a result register held by the sink, and
// then gives a status result. Reset clears the armed flags and the per-rate armed counts;
// the count memories need no clearing pass. The two-entry queue lets requests be taken
// while a sweep runs or a result waits.
`include "assert_macros.svh"

module multi_rate_software_timer_table #(
  parameter int NUM_TIMERS = 16,
  parameter int NUM_RATES = 2,
  parameter int COUNT_WIDTH = 16
) (
  input logic      clk,
  input logic      rst,
  mrstt_req_if.sink   req,
  mrstt_res_if.source res
);
  import mrstt_pkg::*;

  logic push_valid;
  cmd_t push_cmd;
  logic push_ready;
  logic q_valid;
  cmd_t q_cmd;
  logic q_ready;

  logic exp_shown;
  logic exp_clean;
  logic stat_shown;
  logic stat_clean;
  logic single_pop;
  logic single_res;

  mrstt_front #(
    .NUM_TIMERS(NUM_TIMERS),
    .NUM_RATES (NUM_RATES)
  ) u_front (
    .req       (req),
    .push_valid(push_valid),
    .push_cmd  (push_cmd),
    .push_ready(push_ready)
  );

  mrstt_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (push_valid),
    .in_cmd   (push_cmd),
    .in_ready (push_ready),
    .out_valid(q_valid),
    .out_cmd  (q_cmd),
    .out_ready(q_ready)
  );

  mrstt_back #(
    .NUM_TIMERS (NUM_TIMERS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(q_valid),
    .cmd      (q_cmd),
    .cmd_ready(q_ready),
    .res      (res)
  );

  assign exp_shown  = res.valid && res.expired_valid;
  assign exp_clean  = !res.last_item && !res.rate_idle && !res.was_armed;
  assign stat_shown = res.valid && !res.expired_valid;
  assign stat_clean = res.last_item && (res.expired_timer == '0);
  assign single_pop = q_valid && q_ready && (q_cmd.op != OP_TICK);
  assign single_res = res.valid && res.last_item && !res.expired_valid;

  `ASSERT_IMP(a_expiry_fields, clk, rst, exp_shown, exp_clean, "expiry carries status fields")
  `ASSERT_IMP(a_status_fields, clk, rst, stat_shown, stat_clean, "status is not marked last")
  `ASSERT_NXT(a_single_result, clk, rst, single_pop, single_res, "request gave no result")

endmodule

// ===== rtl/mrstt_front.sv =====
// Front end of the timer table: takes requests and classifies them by range.
// Depends on mrstt_pkg and mrstt_req_if.
module mrstt_front #(
  parameter int NUM_TIMERS = 16,
  parameter int NUM_RATES = 2
) (
  mrstt_req_if.sink          req,
  output logic               push_valid,
  output mrstt_pkg::cmd_t    push_cmd,
  input  logic               push_ready
);
  import mrstt_pkg::*;

  assign push_valid = req.valid;
  assign req.ready  = push_ready;

  always_comb begin
    push_cmd.op              = op_t'(req.opcode);
    push_cmd.rate            = req.rate;
    push_cmd.timer_index     = req.timer_index;
    push_cmd.idx_ok          = {3'b000, req.timer_index} < 7'(NUM_TIMERS);
    push_cmd.rate_ok         = {4'b0000, req.rate} < 5'(NUM_RATES);
    push_cmd.start_count     = req.start_count;
    push_cmd.reload_interval = req.reload_interval;
  end

endmodule

// ===== rtl/mrstt_cmd_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on mrstt_pkg for the command record.
module mrstt_cmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  mrstt_pkg::cmd_t in_cmd,
  output logic            in_ready,
  output logic            out_valid,
  output mrstt_pkg::cmd_t out_cmd,
  input  logic            out_ready
);
  import mrstt_pkg::*;

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  assign in_ready  = count != QCNT_W'(QDEPTH);
  assign out_valid = count != '0;
  assign out_cmd   = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

// ===== rtl/mrstt_back.sv =====
// Back end of the timer table: timer memories, armed flags, per-rate armed
// counts, the tick sweep and the result register. Depends on mrstt_pkg, mrstt_res_if.
module mrstt_back #(
  parameter int NUM_TIMERS = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  input  mrstt_pkg::cmd_t cmd,
  output logic            cmd_ready,
  mrstt_res_if.source     res
);
  import mrstt_pkg::*;

  localparam int TIDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int PTR_W = $clog2(NUM_TIMERS + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_STATUS = 2'd2;

  logic [1:0]             state;
  logic [1:0]             state_next;

  logic [COUNT_WIDTH-1:0] count_mem  [NUM_TIMERS];
  logic [COUNT_WIDTH-1:0] reload_mem [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]  armed;
  logic [NUM_TIMERS-1:0]  trate;
  logic [PTR_W-1:0]       rate_cnt [RATE_SLOTS];

  logic [PTR_W-1:0]       scan_ptr;
  logic                   scan_rate;
  logic                   eval_valid;
  logic [TIDX_W-1:0]      eval_addr;
  logic [COUNT_WIDTH-1:0] rd_count;
  logic [COUNT_WIDTH-1:0] rd_reload;

  logic                   out_valid;
  logic                   out_exp;
  logic [IDX_W-1:0]       out_timer;
  logic                   out_idle;
  logic                   out_wa;
  logic                   out_last;
  logic                   out_free;

  logic [TIDX_W+IDX_W-1:0]       idx_wide;
  logic [TIDX_W-1:0]             cmd_addr;
  logic [COUNT_WIDTH+FIELD_CNT_W-1:0] start_wide;
  logic [COUNT_WIDTH+FIELD_CNT_W-1:0] reload_wide;
  logic [COUNT_WIDTH-1:0]        start_c;
  logic [COUNT_WIDTH-1:0]        reload_c;
  logic                          cmd_wa;
  logic                          cmd_trate;
  logic                          idle_in;
  logic                          idle_dis;

  logic [TIDX_W+IDX_W-1:0] ev_wide;
  logic [IDX_W-1:0]        ev_timer;
  logic                    ev_hit;
  logic                    ev_zero;
  logic [COUNT_WIDTH-1:0]  ev_dec;
  logic                    ev_expire;
  logic                    stall;
  logic                    scan_more;
  logic                    scan_start;
  logic                    scan_adv;
  logic                    issue;

  logic                   load_en;
  logic                   ld_exp;
  logic [IDX_W-1:0]       ld_timer;
  logic                   ld_idle;
  logic                   ld_wa;
  logic                   cm_we;
  logic [TIDX_W-1:0]      cm_addr;
  logic [COUNT_WIDTH-1:0] cm_data;
  logic                   rl_we;
  logic                   flag_we;
  logic [TIDX_W-1:0]      flag_addr;
  logic                   flag_val;
  logic                   rate_we;
  logic                   inc_en;
  logic                   inc_sel;
  logic                   dec_en;
  logic                   dec_sel;

  assign idx_wide    = {{TIDX_W{1'b0}}, cmd.timer_index};
  assign cmd_addr    = idx_wide[TIDX_W-1:0];
  assign start_wide  = {{COUNT_WIDTH{1'b0}}, cmd.start_count};
  assign reload_wide = {{COUNT_WIDTH{1'b0}}, cmd.reload_interval};
  assign start_c     = start_wide[COUNT_WIDTH-1:0];
  assign reload_c    = reload_wide[COUNT_WIDTH-1:0];
  assign cmd_wa      = cmd.idx_ok && armed[cmd_addr];
  assign cmd_trate   = trate[cmd_addr];
  assign idle_in     = !cmd.rate_ok || (rate_cnt[cmd.rate] == '0);
  assign idle_dis    = rate_cnt[cmd_trate] == PTR_W'(cmd_wa);

  assign ev_wide   = {{IDX_W{1'b0}}, eval_addr};
  assign ev_timer  = ev_wide[IDX_W-1:0];
  assign ev_hit    = eval_valid && armed[eval_addr] && (trate[eval_addr] == scan_rate);
  assign ev_zero   = rd_count == '0;
  assign ev_dec    = rd_count - COUNT_WIDTH'(1);
  assign ev_expire = ev_hit && !ev_zero && (ev_dec == '0);
  assign out_free  = !out_valid || res.ready;
  assign stall     = ev_expire && !out_free;
  assign scan_more = scan_ptr != PTR_W'(NUM_TIMERS);
  assign issue     = scan_adv && scan_more;

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    scan_start = 1'b0;
    scan_adv   = 1'b0;
    load_en    = 1'b0;
    ld_exp     = 1'b0;
    ld_timer   = '0;
    ld_idle    = 1'b0;
    ld_wa      = 1'b0;
    cm_we      = 1'b0;
    cm_addr    = cmd_addr;
    cm_data    = start_c;
    rl_we      = 1'b0;
    flag_we    = 1'b0;
    flag_addr  = cmd_addr;
    flag_val   = 1'b0;
    rate_we    = 1'b0;
    inc_en     = 1'b0;
    inc_sel    = cmd.rate;
    dec_en     = 1'b0;
    dec_sel    = cmd_trate;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            OP_TICK: begin
              if (cmd.rate_ok) begin
                cmd_ready  = 1'b1;
                scan_start = 1'b1;
                state_next = ST_SCAN;
              end else if (out_free) begin
                cmd_ready = 1'b1;
                load_en   = 1'b1;
                ld_idle   = 1'b1;
              end
            end
            OP_QUERY: begin
              if (out_free) begin
                cmd_ready = 1'b1;
                load_en   = 1'b1;
                ld_idle   = idle_in;
              end
            end
            OP_ARM: begin
              if (out_free) begin
                cmd_ready = 1'b1;
                load_en   = 1'b1;
                ld_wa     = cmd_wa;
                ld_idle   = idle_in && !(cmd.idx_ok && cmd.rate_ok);
                if (cmd.idx_ok && cmd.rate_ok) begin
                  cm_we    = 1'b1;
                  rl_we    = 1'b1;
                  flag_we  = 1'b1;
                  flag_val = 1'b1;
                  rate_we  = 1'b1;
                  inc_en   = 1'b1;
                  dec_en   = cmd_wa;
                end
              end
            end
            OP_DISARM: begin
              if (out_free) begin
                cmd_ready = 1'b1;
                load_en   = 1'b1;
                ld_wa     = cmd_wa;
                ld_idle   = cmd.idx_ok ? idle_dis : idle_in;
                if (cmd.idx_ok) begin
                  flag_we = 1'b1;
                  dec_en  = cmd_wa;
                end
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        cm_addr   = eval_addr;
        cm_data   = ev_dec;
        flag_addr = eval_addr;
        dec_sel   = scan_rate;
        if (!stall) begin
          scan_adv = 1'b1;
          if (ev_hit) begin
            if (ev_zero) begin
              flag_we = 1'b1;
              dec_en  = 1'b1;
            end else if (ev_expire) begin
              load_en  = 1'b1;
              ld_exp   = 1'b1;
              ld_timer = ev_timer;
              if (rd_reload != '0) begin
                cm_we   = 1'b1;
                cm_data = rd_reload;
              end else begin
                flag_we = 1'b1;
                dec_en  = 1'b1;
              end
            end else begin
              cm_we = 1'b1;
            end
          end
          if (!scan_more && !eval_valid) begin
            state_next = ST_STATUS;
          end
        end
      end
      ST_STATUS: begin
        if (out_free) begin
          load_en    = 1'b1;
          ld_idle    = rate_cnt[scan_rate] == '0;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cm_we) begin
      count_mem[cm_addr] <= cm_data;
    end
    if (rl_we) begin
      reload_mem[cmd_addr] <= reload_c;
    end
    if (issue) begin
      rd_count  <= count_mem[scan_ptr[TIDX_W-1:0]];
      rd_reload <= reload_mem[scan_ptr[TIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      armed      <= '0;
      trate      <= '0;
      eval_valid <= 1'b0;
      scan_ptr   <= '0;
      for (int s = 0; s < RATE_SLOTS; s++) begin
        rate_cnt[s] <= '0;
      end
    end else begin
      state <= state_next;
      if (flag_we) begin
        armed[flag_addr] <= flag_val;
      end
      if (rate_we) begin
        trate[flag_addr] <= cmd.rate;
      end
      for (int s = 0; s < RATE_SLOTS; s++) begin
        rate_cnt[s] <= rate_cnt[s] + PTR_W'(inc_en && (inc_sel == 1'(s)))
                                   - PTR_W'(dec_en && (dec_sel == 1'(s)));
      end
      if (scan_start) begin
        scan_ptr   <= '0;
        eval_valid <= 1'b0;
      end else if (scan_adv) begin
        eval_valid <= scan_more;
        if (scan_more) begin
          scan_ptr <= scan_ptr + PTR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      scan_rate <= cmd.rate;
    end
    if (issue) begin
      eval_addr <= scan_ptr[TIDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_en) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      out_exp   <= ld_exp;
      out_timer <= ld_timer;
      out_idle  <= ld_idle;
      out_wa    <= ld_wa;
      out_last  <= !ld_exp;
    end
  end

  assign res.valid         = out_valid;
  assign res.expired_valid = out_exp;
  assign res.expired_timer = out_timer;
  assign res.rate_idle     = out_idle;
  assign res.was_armed     = out_wa;
  assign res.last_item     = out_last;

endmodule
